// ===== hw/rtl/thnd_pkg.sv =====
// ----------------------------------------------------------------------------
// thnd_pkg
// Shared types and constants for the table-driven Huffman nibble decoder:
// operation codes, the result queue geometry and the push bundle that
// carries decoded bytes from the step logic into the result queue.
// ----------------------------------------------------------------------------
package thnd_pkg;

   // Operation codes carried in the request tuser field
   typedef enum logic [2:0] {
      OP_LOAD_NIBBLE = 3'd0,
      OP_LOAD_DIGIT  = 3'd1,
      OP_DECODE_BYTE = 3'd2,
      OP_DECODE_TAIL = 3'd3,
      OP_RESTART     = 3'd4
   } op_type;

   // Result queue geometry
   localparam int RSP_FIFO_DEPTH   = 16;
   localparam int FIFO_PTR_W       = 4;
   localparam int FIFO_LVL_W       = 5;
   // Worst case: three bytes still landing from the finishing transaction
   // plus four from the new one
   localparam int ACCEPT_LEVEL_MAX = RSP_FIFO_DEPTH - 7;

   // Up to three decoded bytes pushed in one cycle, lowest index first
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] sym;
      logic [2:0]      last;
   } rsp_push_type;

endpackage

// ===== hw/rtl/table_huffman_nibble_decoder.sv =====
// ----------------------------------------------------------------------------
// table_huffman_nibble_decoder
// Table-driven Huffman decoder. Nibble and two-bit digit tables sit in
// synchronous memories; decode transactions walk them one digit per cycle.
// ----------------------------------------------------------------------------
// A decode's bytes enter the result queue as its table reads return; the
//   newest byte of a transaction is held back until its tlast is known.
// req stalls while a decode is short of its last step or above 9 queued;
//   rsp drains one byte a cycle while rsp_tready is high.
// Reset: decoder state and start_state go to 255, result queue empties;
//   table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module table_huffman_nibble_decoder #(
   parameter int STATES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: table_state[7:0], table_digit[11:8], entry_first[19:12],
   //        entry_second[27:20], entry_count[29:28], entry_next[37:30],
   //        data_byte[45:38], digit_count[47:46]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // tuser: operation[2:0]
   input  logic [2:0]  req_tuser,
   // tdata: symbol[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // start_state write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);
   import thnd_pkg::*;

   localparam int         SW          = (STATES > 1) ? $clog2(STATES) : 1;
   localparam int         NIB_DEPTH   = STATES * 16;
   localparam int         DIG_DEPTH   = STATES * 4;
   localparam logic [8:0] STATE_LIMIT = 9'(STATES);

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [1:0] count;
      logic [7:0] next;
   } nib_entry_type;

   typedef struct packed {
      logic [7:0] value;
      logic       terminal;
      logic [7:0] next;
   } dig_entry_type;

   // Request fields
   logic [7:0] f_table_state;
   logic [3:0] f_table_digit;
   logic [7:0] f_entry_first;
   logic [7:0] f_entry_second;
   logic [1:0] f_entry_count;
   logic [7:0] f_entry_next;
   logic [7:0] f_data_byte;
   logic [1:0] f_digit_count;

   assign f_table_state  = req_tdata[7:0];
   assign f_table_digit  = req_tdata[11:8];
   assign f_entry_first  = req_tdata[19:12];
   assign f_entry_second = req_tdata[27:20];
   assign f_entry_count  = req_tdata[29:28];
   assign f_entry_next   = req_tdata[37:30];
   assign f_data_byte    = req_tdata[45:38];
   assign f_digit_count  = req_tdata[47:46];

   // Tables and walk state
   nib_entry_type nib_mem [NIB_DEPTH];
   dig_entry_type dig_mem [DIG_DEPTH];

   nib_entry_type nib_rd_ff;
   dig_entry_type dig_rd_ff;
   logic          rd_oor_ff, rd_oor_in;
   logic [7:0]    start_state_ff;
   logic [7:0]    state_ff, state_in;
   logic          busy_ff, busy_in;
   logic          is_tail_ff, is_tail_in;
   logic [1:0]    step_idx_ff, step_idx_in;
   logic [1:0]    steps_ff, steps_in;
   logic [7:0]    data_ff, data_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_sym_ff, pend_sym_in;

   logic          accept;
   logic          start_decode;
   logic          load_in_range;
   logic          last_step;
   logic          more_step;
   nib_entry_type step_nib;
   dig_entry_type step_dig;
   logic [7:0]    step_next;
   logic [7:0]    rd_state;
   logic [7:0]    rd_src;
   logic [1:0]    rd_idx;
   logic [7:0]    dig_shift;
   logic [3:0]    rd_nib_digit;
   logic [1:0]    rd_dig_digit;
   logic [1:0]    nib_count_sat;
   logic [7:0]    nb0, nb1;
   logic [1:0]    n_new, k;
   logic [2:0][7:0] c;
   rsp_push_type  push;
   logic [FIFO_LVL_W-1:0] fifo_level;

   // Handshakes
   assign csr_ready     = 1'b1;
   assign accept        = req_tvalid && req_tready;
   assign last_step     = busy_ff && (2'(step_idx_ff + 2'd1) == steps_ff);
   assign more_step     = busy_ff && !last_step;
   assign req_tready    = (!busy_ff || last_step)
                          && (fifo_level <= FIFO_LVL_W'(ACCEPT_LEVEL_MAX));
   assign start_decode  = accept && ((req_tuser == OP_DECODE_BYTE)
                          || ((req_tuser == OP_DECODE_TAIL) && (f_digit_count != 2'd0)));
   assign load_in_range = ({1'b0, f_table_state} < STATE_LIMIT);
   assign nib_count_sat = (f_entry_count == 2'd3) ? 2'd2 : f_entry_count;

   // Entry seen by the current step; states beyond the table read as zero
   always_comb begin
      step_nib  = rd_oor_ff ? '0 : nib_rd_ff;
      step_dig  = rd_oor_ff ? '0 : dig_rd_ff;
      step_next = is_tail_ff ? step_dig.next : step_nib.next;
   end

   // Read address: next digit of the running walk, or the first digit of
   // a new transaction with the state forwarded from a finishing step
   always_comb begin
      rd_state     = busy_ff ? step_next : state_ff;
      rd_src       = more_step ? data_ff : f_data_byte;
      rd_idx       = more_step ? 2'(step_idx_ff + 2'd1) : 2'd0;
      rd_nib_digit = rd_idx[0] ? rd_src[7:4] : rd_src[3:0];
      dig_shift    = rd_src >> {rd_idx, 1'b0};
      rd_dig_digit = dig_shift[1:0];
      rd_oor_in    = ({1'b0, rd_state} >= STATE_LIMIT);
   end

   // Nibble table: load write and walk read
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == OP_LOAD_NIBBLE) && load_in_range) begin
         nib_mem[{f_table_state[SW-1:0], f_table_digit}] <=
            {f_entry_first, f_entry_second, nib_count_sat, f_entry_next};
      end
      nib_rd_ff <= nib_mem[{rd_state[SW-1:0], rd_nib_digit}];
   end

   // Digit table: load write and walk read
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == OP_LOAD_DIGIT) && load_in_range
          && (f_table_digit[3:2] == 2'b00)) begin
         dig_mem[{f_table_state[SW-1:0], f_table_digit[1:0]}] <=
            {f_entry_first, (f_entry_count != 2'd0), f_entry_next};
      end
      dig_rd_ff <= dig_mem[{rd_state[SW-1:0], rd_dig_digit}];
   end

   // Bytes produced by this step, pending byte first
   always_comb begin
      nb0   = is_tail_ff ? step_dig.value : step_nib.first;
      nb1   = step_nib.second;
      n_new = 2'd0;
      if (busy_ff) begin
         if (is_tail_ff) n_new = {1'b0, step_dig.terminal};
         else            n_new = step_nib.count;
      end
      k    = 2'({1'b0, pend_valid_ff} + n_new);
      c[0] = pend_valid_ff ? pend_sym_ff : nb0;
      c[1] = pend_valid_ff ? nb0 : nb1;
      c[2] = nb1;
   end

   // Push all but the newest byte; the newest waits until we know whether
   // it closes the transaction
   always_comb begin
      push.sym      = c;
      push.count    = 2'd0;
      push.last     = '0;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      if (last_step) begin
         push.count    = k;
         pend_valid_in = 1'b0;
         case (k)
            2'd1:    push.last = 3'b001;
            2'd2:    push.last = 3'b010;
            2'd3:    push.last = 3'b100;
            default: push.last = 3'b000;
         endcase
      end else if (more_step && (n_new != 2'd0)) begin
         push.count    = 2'(k - 2'd1);
         pend_valid_in = 1'b1;
         case (k)
            2'd2:    pend_sym_in = c[1];
            2'd3:    pend_sym_in = c[2];
            default: pend_sym_in = c[0];
         endcase
      end
   end

   // Walk control
   always_comb begin
      busy_in     = start_decode || more_step;
      step_idx_in = more_step ? 2'(step_idx_ff + 2'd1) : 2'd0;
      steps_in    = steps_ff;
      is_tail_in  = is_tail_ff;
      data_in     = data_ff;
      if (start_decode) begin
         is_tail_in = (req_tuser == OP_DECODE_TAIL);
         steps_in   = (req_tuser == OP_DECODE_TAIL) ? f_digit_count : 2'd2;
         data_in    = f_data_byte;
      end
      state_in = state_ff;
      if (busy_ff) state_in = step_next;
      if (accept && (req_tuser == OP_RESTART)) state_in = start_state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         step_idx_ff    <= 2'd0;
         pend_valid_ff  <= 1'b0;
         state_ff       <= 8'd255;
         start_state_ff <= 8'd255;
      end else begin
         busy_ff       <= busy_in;
         step_idx_ff   <= step_idx_in;
         pend_valid_ff <= pend_valid_in;
         state_ff      <= state_in;
         if (csr_valid && csr_ready) start_state_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff    <= steps_in;
      is_tail_ff  <= is_tail_in;
      data_ff     <= data_in;
      pend_sym_ff <= pend_sym_in;
      rd_oor_ff   <= rd_oor_in;
   end

   // Result queue
   thnd_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_sym   (rsp_tdata),
      .out_last  (rsp_tlast),
      .level     (fifo_level)
   );

   // Checks
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_idx_ff < steps_ff))
      else $error("walk step index beyond step count");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy_ff)
      else $error("pending byte outside a decode transaction");

   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_level <= FIFO_LVL_W'(RSP_FIFO_DEPTH))
      else $error("result queue overflow");

   a_restart_state: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_RESTART)) |=> (state_ff == $past(start_state_ff)))
      else $error("restart did not load start state");

endmodule

// ===== hw/rtl/thnd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// thnd_result_fifo
// Result queue of decoded bytes. Takes up to three bytes per cycle from the
// step logic and hands one per cycle to the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module thnd_result_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  thnd_pkg::rsp_push_type         push,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [7:0]                     out_sym,
   output logic                           out_last,
   output logic [thnd_pkg::FIFO_LVL_W-1:0] level
);
   import thnd_pkg::*;

   logic [7:0]            sym_ff  [RSP_FIFO_DEPTH];
   logic                  last_ff [RSP_FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0] level_ff, level_in;
   logic                  pop;

   // Head of queue
   assign out_valid = (level_ff != '0);
   assign out_sym   = sym_ff[rd_ptr_ff];
   assign out_last  = last_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = out_valid && out_ready;

   // Pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      level_in  = level_ff + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage: write up to three consecutive slots
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (2'(j) < push.count) begin
            sym_ff[wr_ptr_ff + FIFO_PTR_W'(j)]  <= push.sym[j];
            last_ff[wr_ptr_ff + FIFO_PTR_W'(j)] <= push.last[j];
         end
      end
   end

endmodule

// ===== tb/tb_table_huffman_nibble_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_table_huffman_nibble_decoder
// Self-checking testbench for the table-driven Huffman nibble decoder. A small
// set of decoder states has both tables filled in completely, and every entry
// loaded into those states points back into the set, so decoding never reads
// an unwritten entry. A directed run covers the field extremes and the corner
// cases. Random traffic follows, one phase per start_state setting. A shadow
// decoder predicts each symbol, and the monitor checks every result
// transaction against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_table_huffman_nibble_decoder;
   import thnd_pkg::*;

   localparam int STATES = 256;
   // watchdog budget for ~310 transactions with the longest idles and stalls
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 50;

   // undefined operation codes, expected to do nothing
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // states whose tables are fully populated, lowest byte is entry 0
   localparam logic [31:0] LIVE_STATES    = {8'hC3, 8'h3C, 8'hFF, 8'h00};
   // start_state value for each random phase
   localparam logic [31:0] START_SETTINGS = {8'hC3, 8'hFF, 8'h3C, 8'h00};

   typedef struct {
      logic [2:0] op;
      logic [7:0] table_state;
      logic [3:0] table_digit;
      logic [7:0] entry_first;
      logic [7:0] entry_second;
      logic [1:0] entry_count;
      logic [7:0] entry_next;
      logic [7:0] data_byte;
      logic [1:0] digit_count;
   } request_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } symbol_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [1:0] count;
      logic [7:0] next;
   } nibble_entry_type;

   typedef struct packed {
      logic [7:0] value;
      logic       terminal;
      logic [7:0] next;
   } digit_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_wdata = '0;

   // shadow decoder
   nibble_entry_type nibble_map [0:STATES*16-1];
   digit_entry_type  digit_map  [0:STATES*4-1];
   logic [7:0]    decoder_state = 8'hFF;
   logic [7:0]    root_state    = 8'hFF;

   request_type pending_requests[$];
   symbol_type  expected_symbols[$];
   request_type req_current;
   int unsigned items_queued   = 0;
   int unsigned items_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned req_gap        = 0;
   int unsigned rsp_stall      = 0;
   bit          req_calm       = 1'b0;
   bit          rsp_calm       = 1'b0;

   table_huffman_nibble_decoder #(
      .STATES (STATES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] live_state(int k);
      return LIVE_STATES[8*k +: 8];
   endfunction

   // Advance the shadow decoder by one request and queue the symbols it yields
   function automatic void step_decoder(request_type r);
      logic [7:0]       produced[$];
      nibble_entry_type ne;
      digit_entry_type  de;
      case (r.op)
         OP_LOAD_NIBBLE: begin
            nibble_map[{r.table_state, r.table_digit}] =
               {r.entry_first, r.entry_second,
                (r.entry_count == 2'd3) ? 2'd2 : r.entry_count, r.entry_next};
         end
         OP_LOAD_DIGIT: begin
            // digit index above three is dropped
            if (r.table_digit < 4'd4)
               digit_map[{r.table_state, r.table_digit[1:0]}] =
                  {r.entry_first, r.entry_count != 2'd0, r.entry_next};
         end
         OP_DECODE_BYTE: begin
            for (int i = 0; i < 2; i++) begin
               ne = nibble_map[{decoder_state, r.data_byte[4*i +: 4]}];
               if (ne.count >= 2'd1) produced.push_back(ne.first);
               if (ne.count >= 2'd2) produced.push_back(ne.second);
               decoder_state = ne.next;
            end
         end
         OP_DECODE_TAIL: begin
            for (int i = 0; i < r.digit_count; i++) begin
               de = digit_map[{decoder_state, r.data_byte[2*i +: 2]}];
               if (de.terminal) produced.push_back(de.value);
               decoder_state = de.next;
            end
         end
         OP_RESTART: decoder_state = root_state;
         default: ;
      endcase
      for (int k = 0; k < produced.size(); k++)
         expected_symbols.push_back({produced[k], k == produced.size() - 1});
   endfunction

   // Request with random content in every field
   function automatic request_type make_request(logic [2:0] op);
      request_type r;
      r.op           = op;
      r.table_state  = 8'($urandom_range(0, 255));
      r.table_digit  = 4'($urandom_range(0, 15));
      r.entry_first  = 8'($urandom_range(0, 255));
      r.entry_second = 8'($urandom_range(0, 255));
      r.entry_count  = 2'($urandom_range(0, 3));
      r.entry_next   = 8'($urandom_range(0, 255));
      r.data_byte    = 8'($urandom_range(0, 255));
      r.digit_count  = 2'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic request_type make_load(logic [2:0] op, logic [7:0] state,
                                             logic [3:0] digit, logic [7:0] first,
                                             logic [7:0] second, logic [1:0] count,
                                             logic [7:0] next);
      request_type r;
      r              = make_request(op);
      r.table_state  = state;
      r.table_digit  = digit;
      r.entry_first  = first;
      r.entry_second = second;
      r.entry_count  = count;
      r.entry_next   = next;
      return r;
   endfunction

   function automatic request_type make_walk(logic [2:0] op, logic [7:0] data,
                                             logic [1:0] digits);
      request_type r;
      r             = make_request(op);
      r.data_byte   = data;
      r.digit_count = digits;
      return r;
   endfunction

   task automatic queue_request(request_type r);
      pending_requests.push_back(r);
      items_queued++;
   endtask

   // Random traffic; live-state loads keep their next state inside the live set
   task automatic queue_random_requests(int n);
      request_type r;
      int          pick;
      logic [7:0]  s;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 34) begin
            r = make_request(OP_DECODE_BYTE);
         end else if (pick < 58) begin
            r = make_request(OP_DECODE_TAIL);
            r.digit_count = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
         end else if (pick < 67) begin
            r = make_request(OP_RESTART);
         end else if (pick < 80) begin
            r = make_request(OP_LOAD_NIBBLE);
            r.table_state = live_state($urandom_range(0, 3));
            r.entry_next  = live_state($urandom_range(0, 3));
         end else if (pick < 89) begin
            r = make_request(OP_LOAD_DIGIT);
            r.table_state = live_state($urandom_range(0, 3));
            r.table_digit = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(4, 15))
                                                         : 4'($urandom_range(0, 3));
            r.entry_next  = live_state($urandom_range(0, 3));
         end else if (pick < 96) begin
            // loads into states that decoding never visits
            r = make_request($urandom_range(0, 1) ? OP_LOAD_DIGIT : OP_LOAD_NIBBLE);
            s = 8'($urandom_range(0, 255));
            for (int j = 0; j < 4; j++)
               if (s == live_state(j)) s ^= 8'h01;
            r.table_state = s;
         end else begin
            r = make_request(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)));
         end
         queue_request(r);
      end
   endtask

   // Block until every request is taken and every symbol checked, then let
   // any load or restart still in flight settle
   task automatic wait_for_drain();
      while (items_accepted != items_queued || expected_symbols.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_decoder(req_current);
            items_accepted++;
            if ($urandom_range(0, 19) == 0) req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 14);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap == 0 && pending_requests.size() != 0) begin
               req_current = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {req_current.digit_count, req_current.data_byte,
                              req_current.entry_next, req_current.entry_count,
                              req_current.entry_second, req_current.entry_first,
                              req_current.table_digit, req_current.table_state};
               req_tuser  <= req_current.op;
            end else begin
               if (req_gap > 0) req_gap--;
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and back-pressure
   always @(posedge clock) begin
      symbol_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_symbols.size() == 0) begin
               mismatch_count++;
               $error("symbol %02h arrived with nothing expected", rsp_tdata);
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_tdata !== want.symbol) begin
                  mismatch_count++;
                  $error("symbol: expected %02h, got %02h", want.symbol, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  mismatch_count++;
                  $error("last: expected %0b, got %0b", want.last, rsp_tlast);
               end
            end
            if ($urandom_range(0, 19) == 0) rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 14);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill both tables of every live state with random entries
      for (int k = 0; k < 4; k++) begin
         for (int d = 0; d < 16; d++)
            queue_request(make_load(OP_LOAD_NIBBLE, live_state(k), 4'(d),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    2'($urandom_range(0, 3)),
                                    live_state($urandom_range(0, 3))));
         for (int d = 0; d < 4; d++)
            queue_request(make_load(OP_LOAD_DIGIT, live_state(k), 4'(d),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    2'($urandom_range(0, 3)),
                                    live_state($urandom_range(0, 3))));
      end

      // directed: count three saturates, byte extremes, empty entry
      queue_request(make_load(OP_LOAD_NIBBLE, 8'hFF, 4'hF, 8'hFF, 8'h00, 2'd3, 8'h00));
      queue_request(make_load(OP_LOAD_NIBBLE, 8'h00, 4'h0, 8'h00, 8'hFF, 2'd2, 8'hFF));
      queue_request(make_load(OP_LOAD_NIBBLE, 8'h00, 4'hF, 8'hA5, 8'h5A, 2'd0, 8'hFF));
      queue_request(make_load(OP_LOAD_NIBBLE, 8'hFF, 4'h0, 8'h11, 8'h22, 2'd1, 8'hFF));
      // any nonzero count marks a digit entry terminal
      queue_request(make_load(OP_LOAD_DIGIT, 8'hFF, 4'h3, 8'hFF, 8'h00, 2'd3, 8'h00));
      queue_request(make_load(OP_LOAD_DIGIT, 8'h00, 4'h0, 8'h00, 8'hFF, 2'd1, 8'hFF));
      queue_request(make_load(OP_LOAD_DIGIT, 8'h00, 4'h3, 8'h77, 8'hFF, 2'd0, 8'h00));
      queue_request(make_load(OP_LOAD_DIGIT, 8'hFF, 4'h0, 8'h80, 8'h00, 2'd2, 8'hFF));
      // digit loads with index above three must be dropped
      queue_request(make_load(OP_LOAD_DIGIT, 8'hFF, 4'hF, 8'hEE, 8'hEE, 2'd1, 8'h00));
      queue_request(make_load(OP_LOAD_DIGIT, 8'h00, 4'h4, 8'hDD, 8'hDD, 2'd2, 8'h00));
      queue_request(make_request(OP_RESTART));
      queue_request(make_walk(OP_DECODE_BYTE, 8'hF0, 2'd0));
      queue_request(make_walk(OP_DECODE_BYTE, 8'h0F, 2'd3));
      queue_request(make_walk(OP_DECODE_TAIL, 8'h03, 2'd3));
      // tail of no digits emits nothing
      queue_request(make_walk(OP_DECODE_TAIL, 8'hFF, 2'd0));
      queue_request(make_walk(OP_DECODE_TAIL, 8'hFF, 2'd1));
      // two-digit tail from wherever the walk stands
      queue_request(make_walk(OP_DECODE_TAIL, 8'h0F, 2'd2));
      queue_request(make_request(OP_SPARE_5));
      queue_request(make_request(OP_SPARE_6));
      queue_request(make_request(OP_SPARE_7));
      // loads into states outside the decode path
      queue_request(make_load(OP_LOAD_NIBBLE, 8'h80, 4'hF, 8'hFF, 8'hFF, 2'd3, 8'hFF));
      queue_request(make_load(OP_LOAD_DIGIT, 8'h7F, 4'h0, 8'h00, 8'h00, 2'd0, 8'h00));
      queue_request(make_request(OP_RESTART));
      queue_request(make_walk(OP_DECODE_BYTE, 8'hFF, 2'd0));
      queue_request(make_walk(OP_DECODE_BYTE, 8'h00, 2'd0));

      // random phases, one per start_state setting
      for (int p = 0; p < 4; p++) begin
         wait_for_drain();
         @(posedge clock);
         csr_valid <= 1'b1;
         csr_wdata <= START_SETTINGS[8*p +: 8];
         do @(posedge clock); while (!csr_ready);
         root_state = START_SETTINGS[8*p +: 8];
         csr_valid <= 1'b0;
         @(negedge clock);
         queue_request(make_request(OP_RESTART));
         queue_random_requests(RANDOM_PER_PHASE);
      end

      wait_for_drain();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
